// File: hw/rtl/fdmc_pkg.sv
// Shared constants, register codes and controller command type for the motion centroid block.
package fdmc_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W     = 8;
	localparam int COORD_W   = 10;
	localparam int WIN_W     = 13;
	localparam int CENT_W    = 12;
	localparam int AREA_W    = 22;
	localparam int SUM_W     = 33;
	localparam int CNT_W     = 21;
	localparam int BOX_W     = 11;
	localparam int CFG_IDX_W = 3;

	// one quotient bit per divider step
	localparam int DIV_STEPS = CENT_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(2000);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [PIX_W-1:0] THRESH_RESET = PIX_W'(60);
	localparam logic [WIN_W-1:0] LEFT_RESET   = WIN_W'(-1);
	localparam logic [WIN_W-1:0] TOP_RESET    = WIN_W'(-1);
	localparam logic [WIN_W-1:0] RIGHT_RESET  = WIN_W'(1024);
	localparam logic [WIN_W-1:0] BOTTOM_RESET = WIN_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_LEFT      = 3'd1,
		REG_TOP       = 3'd2,
		REG_RIGHT     = 3'd3,
		REG_BOTTOM    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic step;
		logic finish;
	} fdmc_cmd_t;

endpackage

// File: hw/rtl/fdmc_if.sv
// Request channel interfaces: pixel pairs in, results out, register writes.
interface fdmc_pix_if import fdmc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIX_W-1:0]   prev_pixel;
	logic [PIX_W-1:0]   curr_pixel;
	logic [COORD_W-1:0] col;
	logic [COORD_W-1:0] row;
	logic               last_pixel;

	modport source (output valid, prev_pixel, curr_pixel, col, row, last_pixel, input ready);
	modport sink (input valid, prev_pixel, curr_pixel, col, row, last_pixel, output ready);
endinterface

interface fdmc_res_if import fdmc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CENT_W-1:0] centroid_x;
	logic [CENT_W-1:0] centroid_y;
	logic [AREA_W-1:0] box_area;
	logic              found;

	modport source (output valid, centroid_x, centroid_y, box_area, found, input ready);
	modport sink (input valid, centroid_x, centroid_y, box_area, found, output ready);
endinterface

interface fdmc_cfg_if import fdmc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WIN_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/fdmc_ctrl.sv
// Controller: pixel acceptance, divider sequencing and result hand-off.
module fdmc_ctrl import fdmc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	input  logic      pix_last,
	output logic      pix_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output fdmc_cmd_t cmd
);

	typedef enum logic {
		ST_ACC,
		ST_DIV
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;
	logic              steps_done;

	assign pix_ready  = (state_q == ST_ACC);
	assign out_valid  = out_valid_q;
	assign steps_done = (cnt_q == STEP_W'(DIV_STEPS));

	assign cmd.accept = pix_valid && pix_ready;
	assign cmd.load   = cmd.accept && pix_last;
	assign cmd.step   = (state_q == ST_DIV) && !steps_done;
	// hand over only when the result slot is empty or being emptied
	assign cmd.finish = (state_q == ST_DIV) && steps_done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_ACC: begin
					if (cmd.load) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (cmd.step) begin
						cnt_q <= cnt_q + STEP_W'(1);
					end else if (cmd.finish) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	a_load_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (!pix_ready && cnt_q == '0))
		else $error("input still open after last pixel");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= STEP_W'(DIV_STEPS))
		else $error("divider step count overran");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result raised without divider finish");

	a_finish_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (pix_ready && out_valid_q))
		else $error("finish did not reopen input and present result");

endmodule

// File: hw/rtl/fdmc_datapath.sv
// Datapath: configuration registers, accumulators, bounding box, shared divider and area.
module fdmc_datapath import fdmc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fdmc_cmd_t            cmd,
	input  logic [PIX_W-1:0]     prev_pixel,
	input  logic [PIX_W-1:0]     curr_pixel,
	input  logic [COORD_W-1:0]   col,
	input  logic [COORD_W-1:0]   row,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIN_W-1:0]     cfg_data,
	output logic [CENT_W-1:0]    centroid_x,
	output logic [CENT_W-1:0]    centroid_y,
	output logic [AREA_W-1:0]    box_area,
	output logic                 found
);

	logic [PIX_W-1:0] thresh_q;
	logic [WIN_W-1:0] left_q, top_q, right_q, bottom_q;

	logic [SUM_W-1:0]   sum_x_q, sum_y_q;
	logic [CNT_W-1:0]   count_q;
	logic [BOX_W-1:0]   min_col_q, min_row_q;
	logic [COORD_W-1:0] max_col_q, max_row_q;

	logic [SUM_W-1:0]   sum_x_nx, sum_y_nx;
	logic [CNT_W-1:0]   count_nx;
	logic [BOX_W-1:0]   min_col_nx, min_row_nx;
	logic [COORD_W-1:0] max_col_nx, max_row_nx;

	logic [SUM_W-1:0]   rem_x_q, rem_y_q, dsh_q;
	logic [CENT_W-1:0]  qx_q, qy_q;
	logic [COORD_W-1:0] dcol_q, drow_q;
	logic [AREA_W-1:0]  area_q;
	logic               nz_q;

	logic [CENT_W-1:0] last_cx_q, last_cy_q;
	logic [AREA_W-1:0] last_area_q;
	logic              found_q;

	logic [PIX_W-1:0]        diff;
	logic signed [WIN_W-1:0] col_s, row_s;
	logic                    in_window, hit;
	logic                    ge_x, ge_y;
	logic [2*COORD_W-1:0]    prod;
	logic [BOX_W-1:0]        dcol_w, drow_w;

	assign diff  = (prev_pixel > curr_pixel) ? prev_pixel - curr_pixel
	                                         : curr_pixel - prev_pixel;
	assign col_s = $signed(WIN_W'(col));
	assign row_s = $signed(WIN_W'(row));

	assign in_window = (col_s > $signed(left_q)) && (col_s < $signed(right_q)) &&
	                   (row_s > $signed(top_q)) && (row_s < $signed(bottom_q)) &&
	                   (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);

	// a full count freezes the frame's statistics
	assign hit = cmd.accept && (diff >= thresh_q) && in_window && (count_q != COUNT_MAX);

	always_comb begin
		sum_x_nx   = sum_x_q;
		sum_y_nx   = sum_y_q;
		count_nx   = count_q;
		min_col_nx = min_col_q;
		max_col_nx = max_col_q;
		min_row_nx = min_row_q;
		max_row_nx = max_row_q;
		if (hit) begin
			sum_x_nx = sum_x_q + SUM_W'({col, 2'b00});
			sum_y_nx = sum_y_q + SUM_W'({row, 2'b00});
			count_nx = count_q + CNT_W'(1);
			if (BOX_W'(col) < min_col_q) min_col_nx = BOX_W'(col);
			if (col > max_col_q)         max_col_nx = col;
			if (BOX_W'(row) < min_row_q) min_row_nx = BOX_W'(row);
			if (row > max_row_q)         max_row_nx = row;
		end
	end

	assign dcol_w = BOX_W'(max_col_nx) - min_col_nx;
	assign drow_w = BOX_W'(max_row_nx) - min_row_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			left_q   <= LEFT_RESET;
			top_q    <= TOP_RESET;
			right_q  <= RIGHT_RESET;
			bottom_q <= BOTTOM_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: thresh_q <= cfg_data[PIX_W-1:0];
				REG_LEFT:      left_q   <= cfg_data;
				REG_TOP:       top_q    <= cfg_data;
				REG_RIGHT:     right_q  <= cfg_data;
				REG_BOTTOM:    bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			count_q   <= '0;
			min_col_q <= BOX_RESET;
			max_col_q <= '0;
			min_row_q <= BOX_RESET;
			max_row_q <= '0;
		end else if (cmd.load) begin
			// frame closes: the divider takes the totals, clear for the next frame
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			count_q   <= '0;
			min_col_q <= BOX_RESET;
			max_col_q <= '0;
			min_row_q <= BOX_RESET;
			max_row_q <= '0;
		end else if (hit) begin
			sum_x_q   <= sum_x_nx;
			sum_y_q   <= sum_y_nx;
			count_q   <= count_nx;
			min_col_q <= min_col_nx;
			max_col_q <= max_col_nx;
			min_row_q <= min_row_nx;
			max_row_q <= max_row_nx;
		end
	end

	assign ge_x = (rem_x_q >= dsh_q);
	assign ge_y = (rem_y_q >= dsh_q);
	assign prod = dcol_q * drow_q;

	// restoring division; the mean of values below 4096 needs only CENT_W quotient bits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_x_q <= sum_x_nx;
			rem_y_q <= sum_y_nx;
			dsh_q   <= SUM_W'(count_nx) << (CENT_W - 1);
			nz_q    <= (count_nx != '0);
			dcol_q  <= dcol_w[COORD_W-1:0];
			drow_q  <= drow_w[COORD_W-1:0];
		end else if (cmd.step) begin
			if (ge_x) rem_x_q <= rem_x_q - dsh_q;
			if (ge_y) rem_y_q <= rem_y_q - dsh_q;
			qx_q   <= {qx_q[CENT_W-2:0], ge_x};
			qy_q   <= {qy_q[CENT_W-2:0], ge_y};
			dsh_q  <= dsh_q >> 1;
			area_q <= {prod, 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cx_q   <= '0;
			last_cy_q   <= '0;
			last_area_q <= '0;
			found_q     <= 1'b0;
		end else if (cmd.finish) begin
			found_q <= nz_q;
			// nothing found: hold the previous result
			if (nz_q) begin
				last_cx_q   <= qx_q;
				last_cy_q   <= qy_q;
				last_area_q <= area_q;
			end
		end
	end

	assign centroid_x = last_cx_q;
	assign centroid_y = last_cy_q;
	assign box_area   = last_area_q;
	assign found      = found_q;

endmodule

// File: hw/rtl/frame_difference_motion_centroid.sv
// Frame difference motion centroid: top level joining controller and datapath.
// Pixel pairs are taken at one per cycle while a frame streams in.
// After the last pixel the input closes for the divider's 12 steps and the hand-off;
// the hand-off, which raises the result valid, waits until the result slot is empty or being emptied.
// The shared restoring divider, one quotient bit per cycle, runs while the input is closed.
// arst_n clears the registers, accumulators and previous result; no clearing pass is needed.
module frame_difference_motion_centroid import fdmc_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	fdmc_pix_if.sink    pix,
	fdmc_res_if.source  res,
	fdmc_cfg_if.sink    cfg
);

	fdmc_cmd_t cmd;

	assign cfg.ready = 1'b1;

	fdmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_last  (pix.last_pixel),
		.pix_ready (pix.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	fdmc_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.prev_pixel (pix.prev_pixel),
		.curr_pixel (pix.curr_pixel),
		.col        (pix.col),
		.row        (pix.row),
		.cfg_write  (cfg.valid && cfg.ready),
		.cfg_index  (cfg.index),
		.cfg_data   (cfg.data),
		.centroid_x (res.centroid_x),
		.centroid_y (res.centroid_y),
		.box_area   (res.box_area),
		.found      (res.found)
	);

endmodule
